@@ rtl/sss_pkg.sv @@
package sss_pkg;

    localparam int VALUE_W  = 16;
    localparam int TARGET_W = 10;
    localparam int COUNT_W  = 30;
    // common width for comparing row indexes with values and targets
    localparam int EXT_W    = 17;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_RESULT
    } sss_state_t;

    typedef struct packed {
        logic issue;        // read issued for one row entry this cycle
        logic use_b;        // entry t - v exists for this index
        logic last;         // item being processed is the final one
        logic clr_we;       // clearing pass writes this cycle
        logic result_load;  // move the captured count into the output register
    } sss_ctl_t;

endpackage

@@ rtl/sss_row_mem.sv @@
module sss_row_mem
    import sss_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [COUNT_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr_a,
    input  logic [ADDR_W-1:0]  rd_addr_b,
    output logic [COUNT_W-1:0] rd_data_a,
    output logic [COUNT_W-1:0] rd_data_b
);

    logic [COUNT_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

@@ rtl/sss_mod_add.sv @@
module sss_mod_add
    import sss_pkg::*;
#(
    parameter int MODULUS = 1000000007
)
(
    input  logic [COUNT_W-1:0] a,
    input  logic [COUNT_W-1:0] b,
    output logic [COUNT_W-1:0] sum
);

    logic [COUNT_W:0] raw;
    logic [COUNT_W:0] reduced;

    // both operands are below the modulus, so one subtract is enough
    always_comb
    begin
        raw     = {1'b0, a} + {1'b0, b};
        reduced = raw - (COUNT_W+1)'(MODULUS);
        if (raw >= (COUNT_W+1)'(MODULUS))
        begin
            sum = reduced[COUNT_W-1:0];
        end
        else
        begin
            sum = raw[COUNT_W-1:0];
        end
    end

endmodule

@@ rtl/sss_ctrl.sv @@
module sss_ctrl
    import sss_pkg::*;
#(
    parameter int MAX_SUM = 1023,
    parameter int IDX_W   = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [VALUE_W-1:0] value,
    input  logic               last,
    input  logic               out_free,
    output logic               in_stall,
    output logic [IDX_W-1:0]   idx,
    output logic [IDX_W-1:0]   rd_addr_b,
    output sss_ctl_t           ctl
);

    sss_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               last_reg, last_next;
    logic               accept;
    logic [EXT_W-1:0]   idx_ext;
    logic [EXT_W-1:0]   value_ext;
    logic [EXT_W-1:0]   diff;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign idx_ext   = {{(EXT_W-IDX_W){1'b0}}, idx_reg};
    assign value_ext = {{(EXT_W-VALUE_W){1'b0}}, value_reg};
    assign diff      = idx_ext - value_ext;

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        value_next = value_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    idx_next   = IDX_W'(MAX_SUM);
                    value_next = value;
                    last_next  = last;
                end
            end
            ST_RUN:
            begin
                if (idx_reg == '0)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_FLUSH:
            begin
                state_next = last_reg ? ST_RESULT : ST_IDLE;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctl             = '0;
        ctl.use_b       = value_ext <= idx_ext;
        ctl.last        = last_reg;
        in_stall        = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_we = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_RUN:
            begin
                ctl.issue = 1'b1;
            end
            ST_FLUSH:
            begin
                ctl.issue = 1'b0;
            end
            ST_RESULT:
            begin
                ctl.result_load = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign idx       = idx_reg;
    assign rd_addr_b = diff[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            idx_reg   <= IDX_W'(MAX_SUM);
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

@@ rtl/subset_sum_count.sv @@
// Flow: one transaction at a time; a new one is accepted only after the previous
//   sweep has drained and, after a last one, its count has moved to a free output. One
//   entry per cycle is swept, descending, through a single modular adder, and a last
//   transaction restores the row as it goes.
// Reset: a clearing pass loads the initial row (one way to reach sum 0); in_stall
//   stays high until it ends. target_sum resets to 0.
module subset_sum_count
    import sss_pkg::*;
#(
    parameter int MAX_SUM = 1023,
    parameter int MODULUS = 1000000007
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                target_sum_we,
    input  logic [TARGET_W-1:0] target_sum,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [VALUE_W-1:0]  value,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [COUNT_W-1:0]  count
);

    localparam int IDX_W = $clog2(MAX_SUM + 1);

    sss_ctl_t           ctl;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   rd_addr_b;
    logic               out_free;

    logic [TARGET_W-1:0] target_sum_reg;
    logic               s1_valid_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s1_use_b_reg;
    logic               s1_last_reg;
    logic [COUNT_W-1:0] hit_reg, hit_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] count_reg;

    logic [COUNT_W-1:0] rd_data_a;
    logic [COUNT_W-1:0] rd_data_b;
    logic [COUNT_W-1:0] add_b;
    logic [COUNT_W-1:0] sum;
    logic               mem_we;
    logic [IDX_W-1:0]   wr_addr;
    logic [COUNT_W-1:0] wr_data;
    logic               idx_is_zero;
    logic               target_hit;
    logic [EXT_W-1:0]   s1_idx_ext;
    logic [EXT_W-1:0]   target_ext;

    assign out_free = !out_valid_reg || !out_stall;

    sss_ctrl #(
        .MAX_SUM (MAX_SUM),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .value     (value),
        .last      (last),
        .out_free  (out_free),
        .in_stall  (in_stall),
        .idx       (idx),
        .rd_addr_b (rd_addr_b),
        .ctl       (ctl)
    );

    sss_row_mem #(
        .DEPTH  (MAX_SUM + 1),
        .ADDR_W (IDX_W)
    ) u_row_mem (
        .clk       (clk),
        .we        (mem_we),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (ctl.issue),
        .rd_addr_a (idx),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign add_b = s1_use_b_reg ? rd_data_b : '0;

    sss_mod_add #(
        .MODULUS (MODULUS)
    ) u_mod_add (
        .a   (rd_data_a),
        .b   (add_b),
        .sum (sum)
    );

    assign s1_idx_ext = {{(EXT_W-IDX_W){1'b0}}, s1_idx_reg};
    assign target_ext = {{(EXT_W-TARGET_W){1'b0}}, target_sum_reg};
    assign target_hit = s1_valid_reg && s1_last_reg && (s1_idx_ext == target_ext);

    // Write-back for entry t; the sweep has already read every entry above t.
    // On a last transaction write the initial row instead of the update.
    always_comb
    begin
        mem_we      = ctl.clr_we || s1_valid_reg;
        wr_addr     = ctl.clr_we ? idx : s1_idx_reg;
        idx_is_zero = ctl.clr_we ? (idx == '0) : (s1_idx_reg == '0);
        if (ctl.clr_we || s1_last_reg)
        begin
            wr_data = idx_is_zero ? COUNT_W'(1) : '0;
        end
        else
        begin
            wr_data = sum;
        end
    end

    always_comb
    begin
        hit_next = hit_reg;
        if (in_valid && !in_stall)
        begin
            hit_next = '0;
        end
        else if (target_hit)
        begin
            hit_next = sum;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_sum_reg <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (target_sum_we)
            begin
                target_sum_reg <= target_sum;
            end
            s1_valid_reg  <= ctl.issue;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= idx;
        s1_use_b_reg <= ctl.use_b;
        s1_last_reg  <= ctl.last;
        hit_reg      <= hit_next;
        if (ctl.result_load)
        begin
            count_reg <= hit_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign count     = count_reg;

    // clearing pass and row update never share the write port
    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.clr_we && s1_valid_reg))
        else $error("clearing pass collides with row update");

    // a new transaction only enters once the previous sweep has drained
    a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !s1_valid_reg && !ctl.issue)
        else $error("input accepted while the row sweep is active");

    // a result never overwrites one still waiting on the output
    a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.result_load |-> !out_valid_reg || !out_stall)
        else $error("result loaded over a stalled output");

    // the output register holds its count while stalled
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(count_reg))
        else $error("stalled result changed");

endmodule
